>>> hw/rtl/glr_pkg.sv
// ----------------------------------------------------------------------------
// Gradient line rasterizer package
// Shared constants, register codes and control structs of the line rasterizer.
// ----------------------------------------------------------------------------
package glr_pkg;

   localparam int FIELD_BITS     = 16;   // coordinate field width on the channels
   localparam int COORD_BITS_DEF = 16;   // default internal coordinate width
   localparam int DIM_BITS       = 15;   // image width and height registers
   localparam int COLOR_BITS     = 24;
   localparam int CHAN_BITS      = 8;
   localparam int NUM_CHANS      = COLOR_BITS / CHAN_BITS;
   localparam int CSR_IDX_BITS   = 1;

   localparam logic [DIM_BITS-1:0] WIDTH_RESET  = 15'd1024;
   localparam logic [DIM_BITS-1:0] HEIGHT_RESET = 15'd768;

   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_STEP = 1'b1;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic load;
      logic advance;
   } walk_ctl_type;

   typedef struct packed {
      logic mul;
      logic shift;
   } lane_ctl_type;

endpackage

>>> hw/rtl/glr_channels.sv
// ----------------------------------------------------------------------------
// Gradient line rasterizer channels
// Valid/ready interfaces for the request, response and register write channels.
// ----------------------------------------------------------------------------
interface glr_req_if;
   logic                                valid;
   logic                                ready;
   logic                                mode;
   logic signed [glr_pkg::FIELD_BITS-1:0] start_x;
   logic signed [glr_pkg::FIELD_BITS-1:0] start_y;
   logic signed [glr_pkg::FIELD_BITS-1:0] end_x;
   logic signed [glr_pkg::FIELD_BITS-1:0] end_y;
   logic [glr_pkg::COLOR_BITS-1:0]      start_color;
   logic [glr_pkg::COLOR_BITS-1:0]      end_color;

   modport source (output valid, mode, start_x, start_y, end_x, end_y, start_color, end_color,
                   input ready);
   modport sink   (input valid, mode, start_x, start_y, end_x, end_y, start_color, end_color,
                   output ready);
endinterface

interface glr_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [glr_pkg::FIELD_BITS-1:0] pixel_x;
   logic signed [glr_pkg::FIELD_BITS-1:0] pixel_y;
   logic [glr_pkg::COLOR_BITS-1:0]      pixel_color;
   logic                                visible;
   logic                                last;

   modport source (output valid, pixel_x, pixel_y, pixel_color, visible, last,
                   input ready);
   modport sink   (input valid, pixel_x, pixel_y, pixel_color, visible, last,
                   output ready);
endinterface

interface glr_csr_if;
   logic                              valid;
   logic                              ready;
   logic [glr_pkg::CSR_IDX_BITS-1:0]  index;
   logic [glr_pkg::DIM_BITS-1:0]      data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/glr_blend_lane.sv
// ----------------------------------------------------------------------------
// Color blend lane
// One 8-bit channel: |c2-c1|*i, then a restoring division by the
// step count, one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module glr_blend_lane #(
   parameter int IDX_BITS = glr_pkg::COORD_BITS_DEF + 1
) (
   input  logic                          clock,
   input  glr_pkg::lane_ctl_type         ctl,
   input  logic [glr_pkg::CHAN_BITS-1:0] base,
   input  logic [glr_pkg::CHAN_BITS-1:0] target,
   input  logic [IDX_BITS-1:0]           step_index,
   input  logic [IDX_BITS-1:0]           step_total,
   output logic [glr_pkg::CHAN_BITS-1:0] channel
);

   localparam int CW  = glr_pkg::CHAN_BITS;
   localparam int PW  = CW + IDX_BITS;
   localparam int DVW = IDX_BITS + CW - 1;

   logic          neg;
   logic [CW-1:0] mag;
   logic          take;

   logic [PW-1:0]  rem_ff,  rem_in;
   logic [DVW-1:0] div_ff,  div_in;
   logic [CW-1:0]  quo_ff,  quo_in;

   assign neg  = target < base;
   assign mag  = neg ? (base - target) : (target - base);
   // A zero step count means equal endpoints: the quotient must stay zero.
   assign take = (div_ff != '0) && (rem_ff >= PW'(div_ff));

   always_comb begin
      rem_in = rem_ff;
      div_in = div_ff;
      quo_in = quo_ff;
      if (ctl.mul) begin
         rem_in = PW'(PW'(mag) * PW'(step_index));
         div_in = {step_total, {(CW-1){1'b0}}};
         quo_in = '0;
      end else if (ctl.shift) begin
         if (take) begin
            rem_in = rem_ff - PW'(div_ff);
         end
         div_in = div_ff >> 1;
         quo_in = {quo_ff[CW-2:0], take};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      div_ff <= div_in;
      quo_ff <= quo_in;
   end

   assign channel = neg ? (base - quo_ff) : (base + quo_ff);

endmodule

>>> hw/rtl/glr_walker.sv
// ----------------------------------------------------------------------------
// Bresenham line walker
// Holds the line state, loads new endpoints and advances one pixel per step.
// ----------------------------------------------------------------------------
module glr_walker #(
   parameter int COORD_BITS = glr_pkg::COORD_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  glr_pkg::walk_ctl_type                  ctl,
   input  logic signed [glr_pkg::FIELD_BITS-1:0]  start_x,
   input  logic signed [glr_pkg::FIELD_BITS-1:0]  start_y,
   input  logic signed [glr_pkg::FIELD_BITS-1:0]  end_x,
   input  logic signed [glr_pkg::FIELD_BITS-1:0]  end_y,
   input  logic [glr_pkg::COLOR_BITS-1:0]         start_color,
   input  logic [glr_pkg::COLOR_BITS-1:0]         end_color,
   output logic                                   active,
   output logic [COORD_BITS-1:0]                  cur_x,
   output logic [COORD_BITS-1:0]                  cur_y,
   output logic                                   last,
   output logic [glr_pkg::COLOR_BITS-1:0]         color_a,
   output logic [glr_pkg::COLOR_BITS-1:0]         color_b,
   output logic [COORD_BITS:0]                    step_index,
   output logic [COORD_BITS:0]                    step_total
);

   localparam int CB  = COORD_BITS;
   localparam int DW  = CB + 1;
   localparam int EW  = CB + 3;
   localparam int E2W = CB + 4;

   logic signed [CB-1:0]  ax, ay, bx, by;
   logic signed [DW-1:0]  dxd, dyd;
   logic [DW-1:0]         adx, ady;
   logic signed [DW:0]    nady;
   logic signed [E2W-1:0] e2;
   logic                  move_x, move_y;
   logic signed [EW-1:0]  inc_x, inc_y;

   logic                  active_ff, active_in;
   logic signed [CB-1:0]  cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic signed [CB-1:0]  tgt_x_ff, tgt_x_in, tgt_y_ff, tgt_y_in;
   logic [DW-1:0]         adx_ff, adx_in;
   logic signed [DW:0]    nady_ff, nady_in;
   logic                  dir_x_neg_ff, dir_x_neg_in, dir_y_neg_ff, dir_y_neg_in;
   logic signed [EW-1:0]  err_ff, err_in;
   logic [DW-1:0]         total_ff, total_in, index_ff, index_in;
   logic [glr_pkg::COLOR_BITS-1:0] color_a_ff, color_a_in, color_b_ff, color_b_in;

   // Coordinates are taken from the low COORD_BITS of the field.
   assign ax = CB'($unsigned(start_x));
   assign ay = CB'($unsigned(start_y));
   assign bx = CB'($unsigned(end_x));
   assign by = CB'($unsigned(end_y));

   assign dxd  = DW'(bx) - DW'(ax);
   assign dyd  = DW'(by) - DW'(ay);
   assign adx  = dxd[DW-1] ? DW'(-dxd) : DW'(dxd);
   assign ady  = dyd[DW-1] ? DW'(-dyd) : DW'(dyd);
   assign nady = -$signed({1'b0, ady});

   assign e2     = {err_ff, 1'b0};
   assign move_x = e2 >= E2W'(nady_ff);
   assign move_y = e2 <= E2W'($signed({1'b0, adx_ff}));
   assign inc_x  = move_x ? EW'(nady_ff) : EW'(0);
   assign inc_y  = move_y ? EW'($signed({1'b0, adx_ff})) : EW'(0);

   assign last = (cur_x_ff == tgt_x_ff) && (cur_y_ff == tgt_y_ff);

   always_comb begin
      active_in    = active_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      tgt_x_in     = tgt_x_ff;
      tgt_y_in     = tgt_y_ff;
      adx_in       = adx_ff;
      nady_in      = nady_ff;
      dir_x_neg_in = dir_x_neg_ff;
      dir_y_neg_in = dir_y_neg_ff;
      err_in       = err_ff;
      total_in     = total_ff;
      index_in     = index_ff;
      color_a_in   = color_a_ff;
      color_b_in   = color_b_ff;
      if (ctl.load) begin
         active_in    = 1'b1;
         cur_x_in     = ax;
         cur_y_in     = ay;
         tgt_x_in     = bx;
         tgt_y_in     = by;
         adx_in       = adx;
         nady_in      = nady;
         dir_x_neg_in = !(ax < bx);
         dir_y_neg_in = !(ay < by);
         err_in       = EW'($signed({1'b0, adx})) + EW'(nady);
         total_in     = (adx > ady) ? adx : ady;
         index_in     = '0;
         color_a_in   = start_color;
         color_b_in   = end_color;
      end else if (ctl.advance) begin
         if (last) begin
            active_in = 1'b0;
         end else begin
            err_in = err_ff + inc_x + inc_y;
            if (move_x) begin
               cur_x_in = dir_x_neg_ff ? (cur_x_ff - CB'(1)) : (cur_x_ff + CB'(1));
            end
            if (move_y) begin
               cur_y_in = dir_y_neg_ff ? (cur_y_ff - CB'(1)) : (cur_y_ff + CB'(1));
            end
            index_in = index_ff + DW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_x_ff     <= cur_x_in;
      cur_y_ff     <= cur_y_in;
      tgt_x_ff     <= tgt_x_in;
      tgt_y_ff     <= tgt_y_in;
      adx_ff       <= adx_in;
      nady_ff      <= nady_in;
      dir_x_neg_ff <= dir_x_neg_in;
      dir_y_neg_ff <= dir_y_neg_in;
      err_ff       <= err_in;
      total_ff     <= total_in;
      index_ff     <= index_in;
      color_a_ff   <= color_a_in;
      color_b_ff   <= color_b_in;
   end

   assign active     = active_ff;
   assign cur_x      = cur_x_ff;
   assign cur_y      = cur_y_ff;
   assign color_a    = color_a_ff;
   assign color_b    = color_b_ff;
   assign step_index = index_ff;
   assign step_total = total_ff;

endmodule

>>> hw/rtl/gradient_line_rasterizer_core.sv
// ----------------------------------------------------------------------------
// Gradient line rasterizer core
// Bresenham line walker with a linear RGB gradient along the line.
// ----------------------------------------------------------------------------
// A load transaction (mode 0) gives no response. A step transaction (mode 1)
// on an active line is accepted, then forms |c2-c1|*i for the three color
// channels, runs a restoring division by the step count that gives the
// eight-bit quotient one bit at a time, and writes the pixel into the response
// register once that register is free. A step transaction with no active line
// is taken and gives nothing. The response register lets a new request in
// while an earlier pixel waits to be taken. Register writes are accepted in
// any cycle.
module gradient_line_rasterizer_core #(
   parameter int COORD_BITS = glr_pkg::COORD_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   glr_req_if.sink    req_bus,
   glr_rsp_if.source  rsp_bus,
   glr_csr_if.sink    csr_bus
);

   localparam int CB    = COORD_BITS;
   localparam int DB    = glr_pkg::DIM_BITS;
   localparam int CW    = glr_pkg::CHAN_BITS;
   localparam int CNT_W = $clog2(CW + 1);
   localparam int CMP_W = (CB > DB) ? CB : DB;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_CALC = 3'b010,
      S_HOLD = 3'b100
   } state_type;

   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [DB-1:0]          width_ff, width_in, height_ff, height_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [glr_pkg::FIELD_BITS-1:0] pix_x_ff, pix_y_ff;
   logic [glr_pkg::COLOR_BITS-1:0] pix_color_ff, pix_color;
   logic                   visible_ff, last_ff;

   logic                   req_fire, csr_fire, out_free, hold_fire, visible;
   glr_pkg::walk_ctl_type  walk_ctl;
   glr_pkg::lane_ctl_type  lane_ctl;

   logic                   walk_active, walk_last;
   logic [CB-1:0]          cur_x, cur_y;
   logic [glr_pkg::COLOR_BITS-1:0] color_a, color_b;
   logic [CB:0]            step_index, step_total;

   assign req_bus.ready = (state_ff == S_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;
   assign csr_fire      = csr_bus.valid;
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign hold_fire     = (state_ff == S_HOLD) && out_free;

   assign walk_ctl.load    = req_fire && (req_bus.mode == glr_pkg::MODE_LOAD);
   assign walk_ctl.advance = hold_fire;
   assign lane_ctl.mul     = (state_ff == S_CALC) && (cnt_ff == '0);
   assign lane_ctl.shift   = (state_ff == S_CALC) && (cnt_ff != '0);

   glr_walker #(
      .COORD_BITS (CB)
   ) u_walker (
      .clock       (clock),
      .reset       (reset),
      .ctl         (walk_ctl),
      .start_x     (req_bus.start_x),
      .start_y     (req_bus.start_y),
      .end_x       (req_bus.end_x),
      .end_y       (req_bus.end_y),
      .start_color (req_bus.start_color),
      .end_color   (req_bus.end_color),
      .active      (walk_active),
      .cur_x       (cur_x),
      .cur_y       (cur_y),
      .last        (walk_last),
      .color_a     (color_a),
      .color_b     (color_b),
      .step_index  (step_index),
      .step_total  (step_total)
   );

   for (genvar g = 0; g < glr_pkg::NUM_CHANS; g++) begin : g_lane
      glr_blend_lane #(
         .IDX_BITS (CB + 1)
      ) u_lane (
         .clock      (clock),
         .ctl        (lane_ctl),
         .base       (color_a[g*CW +: CW]),
         .target     (color_b[g*CW +: CW]),
         .step_index (step_index),
         .step_total (step_total),
         .channel    (pix_color[g*CW +: CW])
      );
   end

   assign visible = !cur_x[CB-1] && !cur_y[CB-1] &&
                    (CMP_W'(cur_x) < CMP_W'(width_ff)) &&
                    (CMP_W'(cur_y) < CMP_W'(height_ff));

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         S_IDLE: begin
            cnt_in = '0;
            if (req_fire && (req_bus.mode == glr_pkg::MODE_STEP) && walk_active) begin
               state_in = S_CALC;
            end
         end
         S_CALC: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(CW)) begin
               state_in = S_HOLD;
            end
         end
         S_HOLD: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_fire) begin
         unique case (csr_bus.index)
            glr_pkg::CSR_IMAGE_WIDTH:  width_in  = csr_bus.data;
            glr_pkg::CSR_IMAGE_HEIGHT: height_in = csr_bus.data;
            default: ;
         endcase
      end
   end

   assign rsp_valid_in = hold_fire || (rsp_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         width_ff     <= glr_pkg::WIDTH_RESET;
         height_ff    <= glr_pkg::HEIGHT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // The pixel is captured before the walker moves on to the next one.
   always_ff @(posedge clock) begin
      if (hold_fire) begin
         pix_x_ff     <= glr_pkg::FIELD_BITS'(cur_x);
         pix_y_ff     <= glr_pkg::FIELD_BITS'(cur_y);
         pix_color_ff <= pix_color;
         visible_ff   <= visible;
         last_ff      <= walk_last;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.pixel_x     = pix_x_ff;
   assign rsp_bus.pixel_y     = pix_y_ff;
   assign rsp_bus.pixel_color = pix_color_ff;
   assign rsp_bus.visible     = visible_ff;
   assign rsp_bus.last        = last_ff;

endmodule
